/* design/ppfd_pkg.sv */
// Shared types and constants for the positional PID controller with filtered derivative.
`timescale 1ns / 1ps

package ppfd_pkg;

	// Fixed field widths.
	localparam int GAIN_W   = 16;
	localparam int WEIGHT_W = 17;
	localparam int BOUND_W  = 31;
	localparam int DRIVE_W  = 16;
	localparam int REG_W    = 32;
	localparam int ADDR_W   = 5;
	localparam int IDX_W    = 3;

	// Serial multiplier: one multiplier bit per cycle, the top bit has negative weight.
	localparam int MULT_W = 18;
	localparam int CNT_W  = 5;
	localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(MULT_W - 1);

	// Fixed-point scaling.
	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h10000;
	localparam int FILT_SHIFT = 16;
	localparam int OUT_SHIFT  = 8;

	// Register indexes.
	localparam logic [IDX_W-1:0] REG_GAIN_PROP    = 3'd0;
	localparam logic [IDX_W-1:0] REG_GAIN_INTEG   = 3'd1;
	localparam logic [IDX_W-1:0] REG_GAIN_DERIV   = 3'd2;
	localparam logic [IDX_W-1:0] REG_DERIV_WEIGHT = 3'd3;
	localparam logic [IDX_W-1:0] REG_INTEG_BOUND  = 3'd4;
	localparam logic [IDX_W-1:0] REG_DRIVE_MIN    = 3'd5;
	localparam logic [IDX_W-1:0] REG_DRIVE_MAX    = 3'd6;

	// Register reset values.
	localparam logic [GAIN_W-1:0]   GAIN_RST      = 16'h0000;
	localparam logic [BOUND_W-1:0]  BOUND_RST     = 31'h7FFF_FFFF;
	localparam logic [DRIVE_W-1:0]  DRIVE_MIN_RST = 16'h8000;
	localparam logic [DRIVE_W-1:0]  DRIVE_MAX_RST = 16'h7FFF;

	// Configuration as seen by the datapath.
	typedef struct packed {
		logic signed [GAIN_W-1:0]  gain_prop;
		logic signed [GAIN_W-1:0]  gain_integ;
		logic signed [GAIN_W-1:0]  gain_deriv;
		logic        [WEIGHT_W-1:0] deriv_weight;
		logic        [BOUND_W-1:0]  integ_bound;
		logic signed [DRIVE_W-1:0] drive_min;
		logic signed [DRIVE_W-1:0] drive_max;
	} cfg_t;

	// Commands from the sequencer to the serial multiply-accumulate unit.
	typedef struct packed {
		logic load;
		logic clear;
	} mac_ctl_t;

endpackage

/* design/positional_pid_filtered_deriv.sv */
// Positional PID controller with low-pass filtered derivative.
// No new item is accepted while one is being computed; sample_stall stays high until then.
// The computation runs five products through one 18-bit bit-serial multiplier, with the
// filter and integral updates after the second product and the output register at the end.
// A finished item waits in the output register while the next one is accepted.
// arst_n clears the controller state to zero and the registers to their defaults at once.
`timescale 1ns / 1ps

module positional_pid_filtered_deriv #(
	parameter int DATA_WIDTH = 16,
	parameter int ACC_WIDTH  = 32
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [ppfd_pkg::ADDR_W-1:0]            paddr,
	input  logic [ppfd_pkg::REG_W-1:0]             pwdata,
	output logic [ppfd_pkg::REG_W-1:0]             prdata,
	output logic                                   pready,
	input  logic                                   sample_valid,
	output logic                                   sample_stall,
	input  logic signed [DATA_WIDTH-1:0]           error_sample,
	output logic                                   drive_valid,
	input  logic                                   drive_stall,
	output logic signed [ppfd_pkg::DRIVE_W-1:0]    drive_value,
	output logic                                   drive_clamped
);

	ppfd_pkg::cfg_t cfg;

	ppfd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ppfd_core #(
		.DATA_WIDTH (DATA_WIDTH),
		.ACC_WIDTH  (ACC_WIDTH)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.sample_valid  (sample_valid),
		.sample_stall  (sample_stall),
		.error_sample  (error_sample),
		.drive_valid   (drive_valid),
		.drive_stall   (drive_stall),
		.drive_value   (drive_value),
		.drive_clamped (drive_clamped)
	);

`ifndef NO_ASSERTIONS
	// An accepted item keeps the input side busy in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(sample_valid && !sample_stall) |=> sample_stall)
		else $error("input taken again directly after an accepted item");

	// A new result only appears at the end of a computation.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(drive_valid) |-> $past(sample_stall))
		else $error("result appeared without a computation");

	// A clamped result sits exactly on one of the limits.
	assert property (@(posedge clk) disable iff (!arst_n)
		(drive_valid && drive_clamped) |->
		(drive_value == cfg.drive_min || drive_value == cfg.drive_max))
		else $error("clamped drive is not on a limit");

	// An unclamped result lies within the limits.
	assert property (@(posedge clk) disable iff (!arst_n)
		(drive_valid && !drive_clamped) |->
		(drive_value >= cfg.drive_min && drive_value <= cfg.drive_max))
		else $error("unclamped drive is outside the limits");
`endif

endmodule

/* design/ppfd_regs.sv */
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps

module ppfd_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [ppfd_pkg::ADDR_W-1:0]        paddr,
	input  logic [ppfd_pkg::REG_W-1:0]         pwdata,
	output logic [ppfd_pkg::REG_W-1:0]         prdata,
	output logic                               pready,
	output ppfd_pkg::cfg_t                     cfg
);

	ppfd_pkg::cfg_t cfg_q;
	logic [ppfd_pkg::IDX_W-1:0] idx;
	logic wr_en;

	assign idx    = paddr[ppfd_pkg::ADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// Register writes in the access cycle; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_prop    <= ppfd_pkg::GAIN_RST;
			cfg_q.gain_integ   <= ppfd_pkg::GAIN_RST;
			cfg_q.gain_deriv   <= ppfd_pkg::GAIN_RST;
			cfg_q.deriv_weight <= ppfd_pkg::WEIGHT_ONE;
			cfg_q.integ_bound  <= ppfd_pkg::BOUND_RST;
			cfg_q.drive_min    <= ppfd_pkg::DRIVE_MIN_RST;
			cfg_q.drive_max    <= ppfd_pkg::DRIVE_MAX_RST;
		end else if (wr_en) begin
			unique case (idx)
				ppfd_pkg::REG_GAIN_PROP: begin
					cfg_q.gain_prop <= pwdata[ppfd_pkg::GAIN_W-1:0];
				end
				ppfd_pkg::REG_GAIN_INTEG: begin
					cfg_q.gain_integ <= pwdata[ppfd_pkg::GAIN_W-1:0];
				end
				ppfd_pkg::REG_GAIN_DERIV: begin
					cfg_q.gain_deriv <= pwdata[ppfd_pkg::GAIN_W-1:0];
				end
				ppfd_pkg::REG_DERIV_WEIGHT: begin
					cfg_q.deriv_weight <= pwdata[ppfd_pkg::WEIGHT_W-1:0];
				end
				ppfd_pkg::REG_INTEG_BOUND: begin
					cfg_q.integ_bound <= pwdata[ppfd_pkg::BOUND_W-1:0];
				end
				ppfd_pkg::REG_DRIVE_MIN: begin
					cfg_q.drive_min <= pwdata[ppfd_pkg::DRIVE_W-1:0];
				end
				ppfd_pkg::REG_DRIVE_MAX: begin
					cfg_q.drive_max <= pwdata[ppfd_pkg::DRIVE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Read data, zero-extended to the bus width.
	always_comb begin
		unique case (idx)
			ppfd_pkg::REG_GAIN_PROP:    prdata = {16'h0000, cfg_q.gain_prop};
			ppfd_pkg::REG_GAIN_INTEG:   prdata = {16'h0000, cfg_q.gain_integ};
			ppfd_pkg::REG_GAIN_DERIV:   prdata = {16'h0000, cfg_q.gain_deriv};
			ppfd_pkg::REG_DERIV_WEIGHT: prdata = {15'h0000, cfg_q.deriv_weight};
			ppfd_pkg::REG_INTEG_BOUND:  prdata = {1'b0, cfg_q.integ_bound};
			ppfd_pkg::REG_DRIVE_MIN:    prdata = {16'h0000, cfg_q.drive_min};
			ppfd_pkg::REG_DRIVE_MAX:    prdata = {16'h0000, cfg_q.drive_max};
			default:                    prdata = '0;
		endcase
	end

endmodule

/* design/ppfd_mac.sv */
// Bit-serial multiply-accumulate unit: one multiplier bit is consumed per cycle.
`timescale 1ns / 1ps

module ppfd_mac #(
	parameter int W = 52
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ppfd_pkg::mac_ctl_t                ctl,
	input  logic [W-1:0]                      x_in,
	input  logic [ppfd_pkg::MULT_W-1:0]       m_in,
	output logic [W-1:0]                      acc,
	output logic                              busy
);

	logic [W-1:0]                  x_q;
	logic [ppfd_pkg::MULT_W-1:0]   m_q;
	logic [ppfd_pkg::CNT_W-1:0]    cnt_q;
	logic                          run_q;
	logic [W-1:0]                  acc_q;
	logic                          last_bit;
	logic [W-1:0]                  addend;
	logic [W-1:0]                  acc_next;

	// The top multiplier bit carries negative weight, so it subtracts.
	assign last_bit = (cnt_q == ppfd_pkg::LAST_BIT);
	assign addend   = last_bit ? ~x_q : x_q;
	assign acc_next = acc_q + addend + {{(W-1){1'b0}}, last_bit};
	assign acc      = acc_q;
	assign busy     = run_q;

	// Bit counter and run flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (ctl.load) begin
			run_q <= 1'b1;
			cnt_q <= '0;
		end else if (run_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (last_bit) begin
				run_q <= 1'b0;
			end
		end
	end

	// Operand shift registers and the accumulator.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			x_q <= x_in;
			m_q <= m_in;
		end else if (run_q) begin
			x_q <= {x_q[W-2:0], 1'b0};
			m_q <= {1'b0, m_q[ppfd_pkg::MULT_W-1:1]};
		end
		if (ctl.clear) begin
			acc_q <= '0;
		end else if (run_q && m_q[0]) begin
			acc_q <= acc_next;
		end
	end

endmodule

/* design/ppfd_core.sv */
// Sequencer and state update for the PID datapath around the serial multiplier.
`timescale 1ns / 1ps

module ppfd_core #(
	parameter int DATA_WIDTH = 16,
	parameter int ACC_WIDTH  = 32
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  ppfd_pkg::cfg_t                         cfg,
	input  logic                                   sample_valid,
	output logic                                   sample_stall,
	input  logic signed [DATA_WIDTH-1:0]           error_sample,
	output logic                                   drive_valid,
	input  logic                                   drive_stall,
	output logic signed [ppfd_pkg::DRIVE_W-1:0]    drive_value,
	output logic                                   drive_clamped
);

	localparam int D    = DATA_WIDTH;
	localparam int A    = ACC_WIDTH;
	localparam int MW   = (D + 1 > A) ? D + 1 : A;
	localparam int ACCW = MW + 18;
	localparam int FW   = ACCW - ppfd_pkg::FILT_SHIFT;
	localparam int OW   = ACCW - ppfd_pkg::OUT_SHIFT;
	localparam int DA   = (A > D) ? A : D;
	localparam int SW   = ((DA > ppfd_pkg::BOUND_W) ? DA : ppfd_pkg::BOUND_W) + 2;
	localparam int DW   = ppfd_pkg::DRIVE_W;

	// Sequencer states.
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_LOAD  = 3'd1;
	localparam logic [2:0] ST_WAIT  = 3'd2;
	localparam logic [2:0] ST_FILT  = 3'd3;
	localparam logic [2:0] ST_INTEG = 3'd4;
	localparam logic [2:0] ST_OUT   = 3'd5;

	// Products in their order of evaluation.
	localparam logic [2:0] P_DW = 3'd0;
	localparam logic [2:0] P_FW = 3'd1;
	localparam logic [2:0] P_KP = 3'd2;
	localparam logic [2:0] P_KI = 3'd3;
	localparam logic [2:0] P_KD = 3'd4;

	logic [2:0] state_q;
	logic [2:0] prod_q;

	logic signed [D-1:0]   e_q;
	logic signed [D-1:0]   prev_q;
	logic signed [D:0]     d_q;
	logic signed [A-1:0]   filt_q;
	logic signed [A-1:0]   sum_q;
	logic [ppfd_pkg::WEIGHT_W-1:0] w_q;

	logic                  drive_valid_q;
	logic signed [DW-1:0]  drive_q;
	logic                  clamped_q;

	logic                           accept;
	logic                           out_load;
	ppfd_pkg::mac_ctl_t             mac_ctl;
	logic [ACCW-1:0]                mac_x;
	logic [ppfd_pkg::MULT_W-1:0]    mac_m;
	logic [ACCW-1:0]                mac_acc;
	logic                           mac_busy;

	logic signed [FW-1:0]  fv;
	logic signed [A-1:0]   filt_new;
	logic signed [SW-1:0]  isum;
	logic signed [SW-1:0]  ibnd;
	logic signed [SW-1:0]  inbnd;
	logic signed [SW-1:0]  iclp;
	logic signed [A-1:0]   sum_new;
	logic signed [OW-1:0]  ov;
	logic signed [OW-1:0]  dmin;
	logic signed [OW-1:0]  dmax;
	logic signed [DW-1:0]  drive_new;
	logic                  clamped_new;

	assign sample_stall  = (state_q != ST_IDLE);
	assign accept        = sample_valid && !sample_stall;
	assign out_load      = (state_q == ST_OUT) && (!drive_valid_q || !drive_stall);
	assign drive_valid   = drive_valid_q;
	assign drive_value   = drive_q;
	assign drive_clamped = clamped_q;

	// Multiplier commands; the accumulator restarts for the filter and for the PID sum.
	always_comb begin
		mac_ctl.load  = (state_q == ST_LOAD);
		mac_ctl.clear = (state_q == ST_LOAD) && ((prod_q == P_DW) || (prod_q == P_KP));
	end

	// Operand selection for the current product.
	always_comb begin
		unique case (prod_q)
			P_DW: begin
				mac_x = {{(ACCW-D-1){d_q[D]}}, d_q};
				mac_m = {1'b0, w_q};
			end
			P_FW: begin
				mac_x = {{(ACCW-A){filt_q[A-1]}}, filt_q};
				mac_m = {1'b0, ppfd_pkg::WEIGHT_ONE - w_q};
			end
			P_KP: begin
				mac_x = {{(ACCW-D){e_q[D-1]}}, e_q};
				mac_m = {{2{cfg.gain_prop[15]}}, cfg.gain_prop};
			end
			P_KI: begin
				mac_x = {{(ACCW-A){sum_q[A-1]}}, sum_q};
				mac_m = {{2{cfg.gain_integ[15]}}, cfg.gain_integ};
			end
			P_KD: begin
				mac_x = {{(ACCW-A){filt_q[A-1]}}, filt_q};
				mac_m = {{2{cfg.gain_deriv[15]}}, cfg.gain_deriv};
			end
			default: begin
				mac_x = '0;
				mac_m = '0;
			end
		endcase
	end

	ppfd_mac #(
		.W (ACCW)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.x_in   (mac_x),
		.m_in   (mac_m),
		.acc    (mac_acc),
		.busy   (mac_busy)
	);

	// Filtered derivative: shift down by the weight scale and saturate to the state width.
	always_comb begin
		fv = mac_acc[ACCW-1:ppfd_pkg::FILT_SHIFT];
		if (fv[FW-1:A-1] == {(FW-A+1){fv[FW-1]}}) begin
			filt_new = fv[A-1:0];
		end else begin
			filt_new = {fv[FW-1], {(A-1){~fv[FW-1]}}};
		end
	end

	// Integral: add the error, clamp to the symmetric bound, then to the state width.
	always_comb begin
		isum  = {{(SW-A){sum_q[A-1]}}, sum_q} + {{(SW-D){e_q[D-1]}}, e_q};
		ibnd  = {{(SW-ppfd_pkg::BOUND_W){1'b0}}, cfg.integ_bound};
		inbnd = -ibnd;
		if (isum < inbnd) begin
			iclp = inbnd;
		end else if (isum > ibnd) begin
			iclp = ibnd;
		end else begin
			iclp = isum;
		end
		if (iclp[SW-1:A-1] == {(SW-A+1){iclp[SW-1]}}) begin
			sum_new = iclp[A-1:0];
		end else begin
			sum_new = {iclp[SW-1], {(A-1){~iclp[SW-1]}}};
		end
	end

	// Output scaling and limits; the lower limit is tested first.
	always_comb begin
		ov   = mac_acc[ACCW-1:ppfd_pkg::OUT_SHIFT];
		dmin = {{(OW-DW){cfg.drive_min[DW-1]}}, cfg.drive_min};
		dmax = {{(OW-DW){cfg.drive_max[DW-1]}}, cfg.drive_max};
		if (ov < dmin) begin
			drive_new   = cfg.drive_min;
			clamped_new = 1'b1;
		end else if (ov > dmax) begin
			drive_new   = cfg.drive_max;
			clamped_new = 1'b1;
		end else begin
			drive_new   = ov[DW-1:0];
			clamped_new = 1'b0;
		end
	end

	// Sequencer and controller state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			prod_q  <= P_DW;
			prev_q  <= '0;
			filt_q  <= '0;
			sum_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						prev_q  <= error_sample;
						prod_q  <= P_DW;
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (!mac_busy) begin
						if (prod_q == P_FW) begin
							state_q <= ST_FILT;
						end else if (prod_q == P_KD) begin
							state_q <= ST_OUT;
						end else begin
							prod_q  <= prod_q + 3'd1;
							state_q <= ST_LOAD;
						end
					end
				end
				ST_FILT: begin
					filt_q  <= filt_new;
					state_q <= ST_INTEG;
				end
				ST_INTEG: begin
					sum_q   <= sum_new;
					prod_q  <= P_KP;
					state_q <= ST_LOAD;
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Sample operands captured at acceptance.
	always_ff @(posedge clk) begin
		if (accept) begin
			e_q <= error_sample;
			d_q <= {error_sample[D-1], error_sample} - {prev_q[D-1], prev_q};
			w_q <= (cfg.deriv_weight > ppfd_pkg::WEIGHT_ONE) ? ppfd_pkg::WEIGHT_ONE
			                                                 : cfg.deriv_weight;
		end
	end

	// Output register: a finished item waits here until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_valid_q <= 1'b0;
		end else if (out_load) begin
			drive_valid_q <= 1'b1;
		end else if (!drive_stall) begin
			drive_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			drive_q   <= drive_new;
			clamped_q <= clamped_new;
		end
	end

endmodule

/* tb/sv/positional_pid_filtered_deriv_tb.sv */
// Self-checking testbench for the positional PID controller with filtered derivative.
`timescale 1ns / 1ps

module positional_pid_filtered_deriv_tb;

	localparam int DATA_W = 16;
	localparam int ACC_W  = 32;
	localparam int BUS_W  = ppfd_pkg::REG_W;
	localparam int DRV_W  = ppfd_pkg::DRIVE_W;
	localparam longint ACC_HI = (64'sd1 <<< (ACC_W - 1)) - 64'sd1;
	localparam longint ACC_LO = -ACC_HI - 64'sd1;
	localparam longint UNITY  = 64'sd65536;
	localparam logic [ppfd_pkg::IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam int NUM_PHASES   = 12;
	localparam int PHASE_ITEMS  = 104;
	localparam int DRAIN_CYCLES = 120;

	// One predicted drive item.
	typedef struct packed {
		logic signed [DRV_W-1:0] value;
		logic                    clamped;
	} drive_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ppfd_pkg::ADDR_W-1:0] paddr = '0;
	logic [BUS_W-1:0] pwdata = '0;
	logic [BUS_W-1:0] prdata;
	logic pready;
	logic sample_valid = 1'b0;
	logic sample_stall;
	logic signed [DATA_W-1:0] error_sample = '0;
	logic drive_valid;
	logic drive_stall = 1'b0;
	logic signed [DRV_W-1:0] drive_value;
	logic drive_clamped;

	// Items waiting to be sent and drive items predicted but not yet seen.
	logic signed [DATA_W-1:0] pending_errors[$];
	drive_t drive_due[$];
	drive_t due_item;

	int issued_cnt = 0;
	int taken_cnt = 0;
	int results_seen = 0;
	int clamped_seen = 0;
	int mismatches = 0;
	int settings_cnt = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int drift_err = 0;

	// Shadow of the register file and of the controller state.
	ppfd_pkg::cfg_t ctl;
	logic signed [DATA_W-1:0] prev_err;
	longint integ_st;
	longint filt_st;

	positional_pid_filtered_deriv #(
		.DATA_WIDTH(DATA_W),
		.ACC_WIDTH (ACC_W)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.error_sample (error_sample),
		.drive_valid  (drive_valid),
		.drive_stall  (drive_stall),
		.drive_value  (drive_value),
		.drive_clamped(drive_clamped)
	);

	always #2 clk = ~clk;

	function automatic longint sat(input longint x, input longint lo, input longint hi);
		if (x < lo)
			return lo;
		if (x > hi)
			return hi;
		return x;
	endfunction

	// Advances the shadow state by one error sample and returns the drive it produces.
	function automatic drive_t pid_drive(input logic signed [DATA_W-1:0] err);
		longint e, w, d, bound, kp, ki, kd, acc, drv, lo, hi;
		drive_t res;
		e = err;
		if (ctl.deriv_weight > ppfd_pkg::WEIGHT_ONE)
			w = UNITY;
		else
			w = ctl.deriv_weight;
		d = e - longint'(prev_err);
		filt_st = sat((d * w + filt_st * (UNITY - w)) >>> ppfd_pkg::FILT_SHIFT,
			ACC_LO, ACC_HI);
		prev_err = err;
		bound = ctl.integ_bound;
		integ_st = sat(sat(integ_st + e, -bound, bound), ACC_LO, ACC_HI);
		kp = $signed(ctl.gain_prop);
		ki = $signed(ctl.gain_integ);
		kd = $signed(ctl.gain_deriv);
		acc = kp * e + ki * integ_st + kd * filt_st;
		drv = acc >>> ppfd_pkg::OUT_SHIFT;
		lo = $signed(ctl.drive_min);
		hi = $signed(ctl.drive_max);
		res.clamped = 1'b0;
		// The lower limit wins when the limits are inverted.
		if (drv < lo) begin
			drv = lo;
			res.clamped = 1'b1;
		end else if (drv > hi) begin
			drv = hi;
			res.clamped = 1'b1;
		end
		res.value = DRV_W'(drv);
		return res;
	endfunction

	task automatic report_mismatch(input string field, input int idx, input longint got,
			input longint want);
		$display("[%0t] mismatch on %s of drive item %0d: got %0d, want %0d",
			$realtime, field, idx, got, want);
		mismatches++;
	endtask

	// Register write: setup cycle, access cycle, shadow updated at the completing edge.
	task automatic reg_write(input logic [ppfd_pkg::IDX_W-1:0] idx,
			input logic [BUS_W-1:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		case (idx)
			ppfd_pkg::REG_GAIN_PROP:
				ctl.gain_prop = data[ppfd_pkg::GAIN_W-1:0];
			ppfd_pkg::REG_GAIN_INTEG:
				ctl.gain_integ = data[ppfd_pkg::GAIN_W-1:0];
			ppfd_pkg::REG_GAIN_DERIV:
				ctl.gain_deriv = data[ppfd_pkg::GAIN_W-1:0];
			ppfd_pkg::REG_DERIV_WEIGHT:
				ctl.deriv_weight = data[ppfd_pkg::WEIGHT_W-1:0];
			ppfd_pkg::REG_INTEG_BOUND:
				ctl.integ_bound = data[ppfd_pkg::BOUND_W-1:0];
			ppfd_pkg::REG_DRIVE_MIN:
				ctl.drive_min = data[ppfd_pkg::DRIVE_W-1:0];
			ppfd_pkg::REG_DRIVE_MAX:
				ctl.drive_max = data[ppfd_pkg::DRIVE_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Waits until every item has been sent and every drive item has come back.
	task automatic settle();
		while (pending_errors.size() != 0 || taken_cnt != issued_cnt || drive_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		settings_cnt++;
	endtask

	// Fills the bits above a register's width with noise, which the block must ignore.
	function automatic logic [BUS_W-1:0] with_noise(input logic [BUS_W-1:0] v, input int w);
		return (BUS_W'($urandom) << w) | v;
	endfunction

	function automatic logic [BUS_W-1:0] pick_gain();
		int g;
		case ($urandom_range(7))
			0, 1: g = $urandom_range(65535);
			2, 3, 4: g = int'($urandom_range(2048)) - 1024;
			5: g = 16'h8000;
			6: g = 16'h7FFF;
			default: g = 0;
		endcase
		return BUS_W'(g) & 32'h0000_FFFF;
	endfunction

	function automatic logic [BUS_W-1:0] pick_weight();
		case ($urandom_range(5))
			0: return 32'd0;
			1: return 32'd65536;
			2: return 32'd131071;
			3: return BUS_W'($urandom_range(131071));
			default: return BUS_W'($urandom_range(65536));
		endcase
	endfunction

	function automatic logic [BUS_W-1:0] pick_bound();
		case ($urandom_range(4))
			0: return 32'd0;
			1: return 32'h7FFF_FFFF;
			2: return BUS_W'($urandom_range(100000));
			3: return BUS_W'($urandom) & 32'h7FFF_FFFF;
			default: return BUS_W'($urandom_range(1000));
		endcase
	endfunction

	// Control errors: full-range and extreme values half the time, else small noise and slow drift.
	function automatic logic signed [DATA_W-1:0] pick_error();
		int v;
		case ($urandom_range(9))
			0, 1, 2, 3: v = int'($urandom_range(65535)) - 32768;
			4, 5, 6: v = int'($urandom_range(128)) - 64;
			7, 8: begin
				v = drift_err + int'($urandom_range(512)) - 256;
				if (v > 32767)
					v = 32767;
				if (v < -32768)
					v = -32768;
			end
			default: v = ($urandom_range(1) != 0) ? 32767 : -32768;
		endcase
		drift_err = v;
		return DATA_W'(v);
	endfunction

	// Writes every register with a fresh setting.
	task automatic shuffle_settings();
		int a, b, t;
		reg_write(ppfd_pkg::REG_GAIN_PROP, with_noise(pick_gain(), ppfd_pkg::GAIN_W));
		reg_write(ppfd_pkg::REG_GAIN_INTEG, with_noise(pick_gain(), ppfd_pkg::GAIN_W));
		reg_write(ppfd_pkg::REG_GAIN_DERIV, with_noise(pick_gain(), ppfd_pkg::GAIN_W));
		reg_write(ppfd_pkg::REG_DERIV_WEIGHT, with_noise(pick_weight(), ppfd_pkg::WEIGHT_W));
		reg_write(ppfd_pkg::REG_INTEG_BOUND, with_noise(pick_bound(), ppfd_pkg::BOUND_W));
		a = int'($urandom_range(65535)) - 32768;
		b = int'($urandom_range(65535)) - 32768;
		case ($urandom_range(3))
			0: begin
				a = -32768;
				b = 32767;
			end
			1: begin
				if (a > b) begin
					t = a;
					a = b;
					b = t;
				end
			end
			2: ;
			default: begin
				a = -int'($urandom_range(300));
				b = $urandom_range(300);
			end
		endcase
		reg_write(ppfd_pkg::REG_DRIVE_MIN,
			with_noise(BUS_W'(a) & 32'h0000_FFFF, ppfd_pkg::DRIVE_W));
		reg_write(ppfd_pkg::REG_DRIVE_MAX,
			with_noise(BUS_W'(b) & 32'h0000_FFFF, ppfd_pkg::DRIVE_W));
	endtask

	// Driver: a new item goes out at the falling edge once the previous one was taken.
	always @(negedge clk) begin
		if (arst_n) begin
			drive_stall <= ($urandom_range(99) < recv_idle_pct);
			if (taken_cnt == issued_cnt) begin
				if (pending_errors.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					sample_valid <= 1'b1;
					error_sample <= pending_errors.pop_front();
					issued_cnt++;
				end else begin
					sample_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check the drive item first, then predict for an accepted error item.
	always @(posedge clk) begin
		if (arst_n) begin
			if (drive_valid && !drive_stall) begin
				if (drive_due.size() == 0) begin
					report_mismatch("presence", results_seen, 1, 0);
				end else begin
					due_item = drive_due.pop_front();
					if (drive_value !== due_item.value)
						report_mismatch("drive_value", results_seen, longint'(drive_value),
							longint'(due_item.value));
					if (drive_clamped !== due_item.clamped)
						report_mismatch("drive_clamped", results_seen, longint'(drive_clamped),
							longint'(due_item.clamped));
				end
				if (drive_clamped === 1'b1)
					clamped_seen++;
				results_seen++;
			end
			if (sample_valid && !sample_stall) begin
				drive_due.push_back(pid_drive(error_sample));
				taken_cnt++;
			end
		end
	end

	// Stimulus and phases.
	initial begin
		ctl.gain_prop = ppfd_pkg::GAIN_RST;
		ctl.gain_integ = ppfd_pkg::GAIN_RST;
		ctl.gain_deriv = ppfd_pkg::GAIN_RST;
		ctl.deriv_weight = ppfd_pkg::WEIGHT_ONE;
		ctl.integ_bound = ppfd_pkg::BOUND_RST;
		ctl.drive_min = ppfd_pkg::DRIVE_MIN_RST;
		ctl.drive_max = ppfd_pkg::DRIVE_MAX_RST;
		prev_err = '0;
		integ_st = 0;
		filt_st = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Defaults after reset: all gains zero.
		pending_errors.push_back(16'sh7FFF);
		pending_errors.push_back(16'sh8000);
		settle();

		// Unity proportional gain over the extremes of the error.
		reg_write(ppfd_pkg::REG_GAIN_PROP, 32'hABCD_0100);
		pending_errors.push_back(16'sh7FFF);
		pending_errors.push_back(16'sh8000);
		pending_errors.push_back(16'sh0000);
		pending_errors.push_back(16'shFFFF);
		settle();

		// Rounding toward minus infinity: a filtered derivative of minus one holds.
		reg_write(ppfd_pkg::REG_GAIN_PROP, 32'h0000_0000);
		reg_write(ppfd_pkg::REG_GAIN_DERIV, 32'h0000_0100);
		reg_write(ppfd_pkg::REG_DERIV_WEIGHT, 32'h0000_8000);
		pending_errors.push_back(16'shFFFF);
		pending_errors.push_back(16'shFFFF);
		pending_errors.push_back(16'shFFFF);
		pending_errors.push_back(16'sh0000);
		settle();

		// Filter weight above one behaves as one.
		reg_write(ppfd_pkg::REG_GAIN_DERIV, 32'hFFFF_8000);
		reg_write(ppfd_pkg::REG_DERIV_WEIGHT, 32'h0001_FFFF);
		pending_errors.push_back(16'sh7FFF);
		pending_errors.push_back(16'sh8000);
		settle();
		reg_write(ppfd_pkg::REG_DERIV_WEIGHT, 32'h0001_0001);
		pending_errors.push_back(16'sh0064);
		settle();

		// Integral clamp applies with zero integral gain, then shows with full gain.
		reg_write(ppfd_pkg::REG_GAIN_DERIV, 32'h0000_0000);
		reg_write(ppfd_pkg::REG_GAIN_INTEG, 32'h0000_0000);
		reg_write(ppfd_pkg::REG_INTEG_BOUND, 32'h0000_0005);
		pending_errors.push_back(16'sd1000);
		settle();
		reg_write(ppfd_pkg::REG_GAIN_INTEG, 32'h0000_7FFF);
		pending_errors.push_back(16'sd1000);
		pending_errors.push_back(-16'sd1000);
		settle();
		reg_write(ppfd_pkg::REG_INTEG_BOUND, 32'h8000_0000);
		pending_errors.push_back(16'sd7);
		settle();

		// Inverted drive limits: the lower limit is tested first.
		reg_write(ppfd_pkg::REG_GAIN_INTEG, 32'h0000_0000);
		reg_write(ppfd_pkg::REG_GAIN_PROP, 32'h0000_0100);
		reg_write(ppfd_pkg::REG_DRIVE_MIN, 32'h0000_0064);
		reg_write(ppfd_pkg::REG_DRIVE_MAX, 32'hFFFF_FF9C);
		pending_errors.push_back(16'sd0);
		pending_errors.push_back(16'sd200);
		pending_errors.push_back(16'sd50);
		settle();

		// A write to an unmapped register must change nothing.
		reg_write(REG_UNUSED, BUS_W'($urandom));
		pending_errors.push_back(16'sd50);
		settle();

		// Random phases: sender idles lightly, then the receiver, then neither.
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			if (ph < NUM_PHASES / 3) begin
				send_idle_pct = 9;
				recv_idle_pct = 58;
			end else if (ph < 2 * NUM_PHASES / 3) begin
				send_idle_pct = 58;
				recv_idle_pct = 9;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			shuffle_settings();
			for (int n = 0; n < PHASE_ITEMS; n++)
				pending_errors.push_back(pick_error());
			settle();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d error items under %0d register settings; %0d drive items checked,",
			issued_cnt, settings_cnt, results_seen);
		$display("%0d of them clamped, with %0d mismatches.", clamped_seen, mismatches);
		if (mismatches == 0 && drive_due.size() == 0)
			$display("** positional_pid_filtered_deriv: PASSED **");
		else
			$display("** positional_pid_filtered_deriv: FAILED **");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#4000000;
		$display("Timed out with %0d drive items outstanding.", drive_due.size());
		$display("** positional_pid_filtered_deriv: FAILED **");
		$finish;
	end

endmodule
